// ===== hw/rtl/hed_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hed_pkg;

    // parser modes
    localparam logic [2:0] MODE_PLAIN  = 3'd0;
    localparam logic [2:0] MODE_TAG    = 3'd1;
    localparam logic [2:0] MODE_NAME   = 3'd2;
    localparam logic [2:0] MODE_HASH   = 3'd3;
    localparam logic [2:0] MODE_DIGITS = 3'd4;
    localparam logic [2:0] MODE_SKIP   = 3'd5;

    // emit phases, also the controller state codes
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_LIT  = 3'd1;
    localparam logic [2:0] PH_UTF  = 3'd2;
    localparam logic [2:0] PH_TAIL = 3'd3;
    localparam logic [2:0] PH_MARK = 3'd4;

    localparam int         PREFIX_DEPTH = 7;
    localparam int         NUM_ENT      = 8;
    localparam logic [20:0] CODE_LIMIT  = 21'h110000;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_XL   = 8'h78;
    localparam logic [7:0] CH_XU   = 8'h58;

    // what one accepted byte produces
    typedef struct packed {
        logic [3:0] lit_n;   // '&' plus buffered letters
        logic [2:0] utf_n;   // utf-8 bytes of one code point
        logic       tail_en; // one single byte at the end
        logic       marker;  // end of text with nothing to give
        logic       last;
    } plan_t;

    typedef struct packed {
        logic       accept;
        logic       load;
        logic [2:0] phase;
        logic [2:0] idx;
        logic       run_last;
    } hed_cmd_t;

    typedef struct packed {
        plan_t nxt;
        plan_t cur;
    } hed_stat_t;

    // entity text, first char in the top byte, closing ';' included
    function automatic logic [55:0] ent_text(input logic [2:0] k);
        logic [55:0] t;
        unique case (k)
            3'd0: t = {"nbsp;", 16'h0};
            3'd1: t = {"amp;", 24'h0};
            3'd2: t = {"lt;", 32'h0};
            3'd3: t = {"gt;", 32'h0};
            3'd4: t = {"quot;", 16'h0};
            3'd5: t = {"apos;", 16'h0};
            3'd6: t = {"euro;", 16'h0};
            3'd7: t = "hellip;";
        endcase
        return t;
    endfunction

    function automatic logic [2:0] ent_len(input logic [2:0] k);
        logic [2:0] n;
        unique case (k)
            3'd0: n = 3'd5;
            3'd1: n = 3'd4;
            3'd2: n = 3'd3;
            3'd3: n = 3'd3;
            3'd4: n = 3'd5;
            3'd5: n = 3'd5;
            3'd6: n = 3'd5;
            3'd7: n = 3'd7;
        endcase
        return n;
    endfunction

    // code point each entity stands for (nbsp gives a plain space)
    function automatic logic [20:0] ent_cp(input logic [2:0] k);
        logic [20:0] c;
        unique case (k)
            3'd0: c = 21'h00020;
            3'd1: c = 21'h00026;
            3'd2: c = 21'h0003C;
            3'd3: c = 21'h0003E;
            3'd4: c = 21'h00022;
            3'd5: c = 21'h00027;
            3'd6: c = 21'h020AC;
            3'd7: c = 21'h02026;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ent_char(input logic [2:0] k, input logic [2:0] pos);
        logic [55:0] t;
        t = ent_text(k) << (8 * pos);
        return t[55:48];
    endfunction

    // bit 4 set means not a digit
    function automatic logic [4:0] digit_of(input logic [7:0] b, input logic hex);
        logic [4:0] d;
        if (b >= 8'h30 && b <= 8'h39)
            d = {1'b0, b[3:0]};
        else if (hex && ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)))
            d = {1'b0, b[3:0] + 4'd9};
        else
            d = 5'd16;
        return d;
    endfunction

    function automatic logic [2:0] utf8_len(input logic [20:0] cp);
        logic [2:0] n;
        if (cp < 21'h80)
            n = 3'd1;
        else if (cp < 21'h800)
            n = 3'd2;
        else if (cp < 21'h10000)
            n = 3'd3;
        else if (cp < CODE_LIMIT)
            n = 3'd4;
        else
            n = 3'd0;
        return n;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] n,
                                             input logic [2:0] j);
        logic [7:0] b;
        unique case (n)
            3'd1: b = {1'b0, cp[6:0]};
            3'd2: b = (j == 3'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            3'd3:
            begin
                unique case (j)
                    3'd0:    b = {4'hE, cp[15:12]};
                    3'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            3'd4:
            begin
                unique case (j)
                    3'd0:    b = {5'b11110, cp[20:18]};
                    3'd1:    b = {2'b10, cp[17:12]};
                    3'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hed_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface hed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hed_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface hed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       text_end;

    modport source (output valid, output out_byte, output byte_valid, output run_last,
                    output text_end, input ready);
    modport sink (input valid, input out_byte, input byte_valid, input run_last,
                  input text_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hed_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hed_datapath import hed_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_we,
    input  wire logic      cfg_data,
    input  wire logic [7:0] in_byte,
    input  wire logic      in_last,
    input  wire hed_cmd_t  cmd,
    output hed_stat_t      stat,
    output logic [7:0]     out_byte,
    output logic           byte_valid,
    output logic           run_last,
    output logic           text_end
);

    logic        rt_reg;
    logic [2:0]  mode_reg, mode_next;
    logic [7:0]  cand_reg, cand_next;
    logic [2:0]  mlen_reg, mlen_next;
    logic [20:0] code_reg, code_next;
    logic        hex_reg, hex_next;
    logic        seen_reg, seen_next;
    logic [7:0]  prefix_reg [PREFIX_DEPTH];
    plan_t       plan_reg, plan_next;
    logic [20:0] cp_reg, cp_next;
    logic [7:0]  tail_reg, tail_next;
    logic [7:0]  out_byte_reg;
    logic        byte_valid_reg;
    logic        run_last_reg;
    logic        text_end_reg;

    logic [7:0]  cand_hit;
    logic        name_done;
    logic [2:0]  done_k;
    logic        fresh;
    logic        hexv;
    logic        dig_mode;
    logic [4:0]  dig;
    logic [24:0] prod;
    logic [20:0] sat;
    logic        pwr_en;
    logic        utf_en;
    logic [3:0]  lit_n;
    logic [2:0]  utf_n;
    logic        tail_en;
    logic [3:0]  total;
    logic [7:0]  sel_byte;

    // which entity names still fit the letters so far
    always_comb
    begin
        cand_hit  = '0;
        name_done = 1'b0;
        done_k    = '0;
        for (int k = 0; k < NUM_ENT; k++)
        begin
            if (cand_reg[k] && (mlen_reg < ent_len(3'(k)))
                && (ent_char(3'(k), mlen_reg) == in_byte))
                cand_hit[k] = 1'b1;
        end
        for (int k = NUM_ENT - 1; k >= 0; k--)
        begin
            if (cand_hit[k] && (({1'b0, mlen_reg} + 4'd1) == {1'b0, ent_len(3'(k))}))
            begin
                name_done = 1'b1;
                done_k    = 3'(k);
            end
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        cand_next = cand_reg;
        mlen_next = mlen_reg;
        code_next = code_reg;
        hex_next  = hex_reg;
        seen_next = seen_reg;
        pwr_en    = 1'b0;
        lit_n     = '0;
        cp_next   = '0;
        utf_en    = 1'b0;
        tail_en   = 1'b0;
        tail_next = in_byte;
        fresh     = 1'b0;
        hexv      = hex_reg;
        dig_mode  = 1'b0;

        unique case (mode_reg)
            MODE_TAG:
            begin
                if (in_byte == CH_GT)
                    mode_next = MODE_PLAIN;
            end
            MODE_SKIP:
            begin
                if (in_byte == CH_SEMI)
                    mode_next = MODE_PLAIN;
            end
            MODE_HASH:
            begin
                if (in_byte == CH_XL || in_byte == CH_XU)
                begin
                    mode_next = MODE_DIGITS;
                    hex_next  = 1'b1;
                end
                else
                begin
                    hex_next = 1'b0;
                    hexv     = 1'b0;
                    dig_mode = 1'b1;
                end
            end
            MODE_DIGITS:
            begin
                dig_mode = 1'b1;
            end
            MODE_NAME:
            begin
                if (mlen_reg == 3'd0 && in_byte == CH_HASH)
                begin
                    cand_next = '0;
                    mlen_next = '0;
                    code_next = '0;
                    hex_next  = 1'b0;
                    seen_next = 1'b0;
                    mode_next = MODE_HASH;
                end
                else if (cand_hit != '0)
                begin
                    if (name_done)
                    begin
                        cp_next   = ent_cp(done_k);
                        utf_en    = 1'b1;
                        cand_next = '0;
                        mlen_next = '0;
                        mode_next = MODE_PLAIN;
                    end
                    else
                    begin
                        if (mlen_reg < 3'(PREFIX_DEPTH))
                        begin
                            pwr_en    = 1'b1;
                            mlen_next = mlen_reg + 3'd1;
                        end
                        cand_next = cand_hit;
                    end
                end
                else
                begin
                    // no name fits: give the text back, then treat the byte as new
                    lit_n     = {1'b0, mlen_reg} + 4'd1;
                    cand_next = '0;
                    mlen_next = '0;
                    mode_next = MODE_PLAIN;
                    fresh     = 1'b1;
                end
            end
            default:
            begin
                fresh = 1'b1;
            end
        endcase

        dig  = digit_of(in_byte, hexv);
        prod = hexv ? {code_reg, dig[3:0]} : 25'(code_reg) * 25'd10 + 25'(dig[3:0]);
        sat  = (prod >= 25'(CODE_LIMIT)) ? CODE_LIMIT : prod[20:0];

        if (dig_mode)
        begin
            if (!dig[4])
            begin
                code_next = sat;
                seen_next = 1'b1;
                mode_next = MODE_DIGITS;
            end
            else
            begin
                if (seen_reg)
                begin
                    cp_next = code_reg;
                    utf_en  = 1'b1;
                end
                cand_next = '0;
                mlen_next = '0;
                code_next = '0;
                hex_next  = 1'b0;
                seen_next = 1'b0;
                mode_next = (in_byte == CH_SEMI) ? MODE_PLAIN : MODE_SKIP;
            end
        end

        if (fresh)
        begin
            if (rt_reg && in_byte == CH_LT)
                mode_next = MODE_TAG;
            else if (in_byte == CH_AMP)
            begin
                mode_next = MODE_NAME;
                cand_next = '1;
                mlen_next = '0;
            end
            else
                tail_en = 1'b1;
        end

        // end of text flushes whatever is pending
        if (in_last)
        begin
            if (mode_next == MODE_NAME)
            begin
                if (mlen_next == 3'd0)
                begin
                    tail_en   = 1'b1;
                    tail_next = CH_AMP;
                end
                else
                    lit_n = {1'b0, mlen_next} + 4'd1;
            end
            else if (mode_next == MODE_DIGITS && seen_next)
            begin
                cp_next = code_next;
                utf_en  = 1'b1;
            end
            mode_next = MODE_PLAIN;
            cand_next = '0;
            mlen_next = '0;
            code_next = '0;
            hex_next  = 1'b0;
            seen_next = 1'b0;
        end

        utf_n = utf_en ? utf8_len(cp_next) : 3'd0;
        total = lit_n + {1'b0, utf_n} + {3'b0, tail_en};

        plan_next.lit_n   = lit_n;
        plan_next.utf_n   = utf_n;
        plan_next.tail_en = tail_en;
        plan_next.marker  = in_last && (total == 4'd0);
        plan_next.last    = in_last;
    end

    assign stat.nxt = plan_next;
    assign stat.cur = plan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rt_reg   <= 1'b0;
            mode_reg <= MODE_PLAIN;
            cand_reg <= '0;
            mlen_reg <= '0;
            code_reg <= '0;
            hex_reg  <= 1'b0;
            seen_reg <= 1'b0;
            plan_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                rt_reg <= cfg_data;
            if (cmd.accept)
            begin
                mode_reg <= mode_next;
                cand_reg <= cand_next;
                mlen_reg <= mlen_next;
                code_reg <= code_next;
                hex_reg  <= hex_next;
                seen_reg <= seen_next;
                plan_reg <= plan_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cp_reg   <= cp_next;
            tail_reg <= tail_next;
            if (pwr_en)
                prefix_reg[mlen_reg] <= in_byte;
        end
        if (cmd.load)
        begin
            out_byte_reg   <= sel_byte;
            byte_valid_reg <= (cmd.phase != PH_MARK);
            run_last_reg   <= cmd.run_last;
            text_end_reg   <= cmd.run_last && plan_reg.last;
        end
    end

    always_comb
    begin
        unique case (cmd.phase)
            PH_LIT:  sel_byte = (cmd.idx == 3'd0) ? CH_AMP : prefix_reg[cmd.idx - 3'd1];
            PH_UTF:  sel_byte = utf8_byte(cp_reg, plan_reg.utf_n, cmd.idx);
            PH_TAIL: sel_byte = tail_reg;
            default: sel_byte = 8'h00;
        endcase
    end

    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign run_last   = run_last_reg;
    assign text_end   = text_end_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/hed_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hed_ctrl import hed_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire hed_stat_t stat,
    output hed_cmd_t       cmd
);

    logic [2:0] state_reg, state_next;
    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       load;
    logic       phase_end;
    logic [2:0] follow;
    logic       run_last;

    // next nonempty phase after the given one
    function automatic logic [2:0] next_after(input plan_t p, input logic [2:0] from);
        logic [2:0] s;
        s = PH_IDLE;
        if (from == PH_IDLE && p.lit_n != 4'd0)
            s = PH_LIT;
        else if ((from == PH_IDLE || from == PH_LIT) && p.utf_n != 3'd0)
            s = PH_UTF;
        else if ((from == PH_IDLE || from == PH_LIT || from == PH_UTF) && p.tail_en)
            s = PH_TAIL;
        else if (from == PH_IDLE && p.marker)
            s = PH_MARK;
        return s;
    endfunction

    assign in_ready = (state_reg == PH_IDLE);
    assign accept   = in_valid && in_ready;
    assign load     = (state_reg != PH_IDLE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        unique case (state_reg)
            PH_LIT:  phase_end = ({1'b0, idx_reg} == stat.cur.lit_n - 4'd1);
            PH_UTF:  phase_end = (idx_reg == stat.cur.utf_n - 3'd1);
            PH_TAIL: phase_end = 1'b1;
            PH_MARK: phase_end = 1'b1;
            default: phase_end = 1'b0;
        endcase
        follow   = next_after(stat.cur, state_reg);
        run_last = phase_end && (follow == PH_IDLE);

        state_next = state_reg;
        idx_next   = idx_reg;
        if (state_reg == PH_IDLE)
        begin
            if (accept)
                state_next = next_after(stat.nxt, PH_IDLE);
        end
        else if (load)
        begin
            if (phase_end)
            begin
                state_next = follow;
                idx_next   = '0;
            end
            else
                idx_next = idx_reg + 3'd1;
        end

        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PH_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cmd.accept   = accept;
    assign cmd.load     = load;
    assign cmd.phase    = state_reg;
    assign cmd.idx      = idx_reg;
    assign cmd.run_last = run_last;

`ifndef SYNTHESIS
    a_run_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (load && run_last) |=> (state_reg == PH_IDLE))
        else $error("sequencer kept going after the final word of a byte");

    a_lit_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == PH_LIT) |-> ({1'b0, idx_reg} < stat.cur.lit_n))
        else $error("literal index past buffered letters");

    a_utf_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == PH_UTF) |-> (idx_reg < stat.cur.utf_n))
        else $error("utf-8 index past encoded length");

    a_mark_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == PH_MARK) |-> stat.cur.last)
        else $error("end marker without end of text");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/html_entity_to_utf8_decoder_top.sv =====
// HTML entity decoder: takes text one byte per word on the text channel and gives the
// decoded bytes on the decoded channel. The entities nbsp, amp, lt, gt, quot, apos,
// euro and hellip and decimal or hex numeric references turn into UTF-8; a numeric
// reference is followed by skipping through the next ';', and with the tag bit set
// (cfg_data under cfg_we) everything from '<' through '>' is dropped. A byte is taken
// only while the emit sequencer is idle; its results (0 to 8 words) leave through a
// single output register at one per cycle while decoded.ready allows, as the sequencer
// walks the literal letters, the UTF-8 bytes and a trailing byte in turn.
// A byte marked in_last that leaves nothing to give yields one word with byte_valid 0.
`timescale 1ns / 1ps
`default_nettype none

module html_entity_to_utf8_decoder_top import hed_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    hed_in_if.sink     text,
    hed_out_if.source  decoded,
    input  wire logic  cfg_we,
    input  wire logic  cfg_data
);

    hed_cmd_t  cmd;
    hed_stat_t stat;

    hed_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (text.valid),
        .in_ready  (text.ready),
        .out_valid (decoded.valid),
        .out_ready (decoded.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    hed_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_byte    (text.in_byte),
        .in_last    (text.in_last),
        .cmd        (cmd),
        .stat       (stat),
        .out_byte   (decoded.out_byte),
        .byte_valid (decoded.byte_valid),
        .run_last   (decoded.run_last),
        .text_end   (decoded.text_end)
    );

endmodule

`default_nettype wire
